// ===== rtl/aoc_pkg.sv =====
// ----------------------------------------------------------------------------
// aoc_pkg: shared types and constants of the accelerometer offset calibrator
// Item and result words, lane control, laser command and request codes.
// ----------------------------------------------------------------------------
package aoc_pkg;

	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned SUM_W      = 26;
	// magnitude of an axis sum: at most 1024 * 32768 = 2**25
	localparam int unsigned MAG_W      = 26;
	localparam int unsigned TRIALS_DEF = 16;
	localparam int unsigned LCMD_W     = 2;
	localparam int unsigned LIMIT_W    = 8;

	localparam logic [LIMIT_W-1:0] FAIL_LIMIT_RESET = 8'd10;

	localparam logic [LCMD_W-1:0] LCMD_NONE = 2'd0;
	localparam logic [LCMD_W-1:0] LCMD_ON   = 2'd1;
	localparam logic [LCMD_W-1:0] LCMD_OFF  = 2'd2;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_REQ  = 1'b1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic    op;
		logic    read_ok;
		sample_t acc_x;
		sample_t acc_y;
		sample_t acc_z;
		logic    laser_granted;
	} in_item_t;

	typedef struct packed {
		logic [LCMD_W-1:0] laser_cmd;
		logic              calib_done;
		logic              calib_retry;
		logic              sample_valid;
		sample_t           out_x;
		sample_t           out_y;
		sample_t           out_z;
		sample_t           offset_x;
		sample_t           offset_y;
		sample_t           offset_z;
	} out_item_t;

	// per-item decisions that ride down the pipeline
	typedef struct packed {
		logic [LCMD_W-1:0] laser_cmd;
		logic              done;
		logic              retry;
		logic              valid;
	} stage_info_t;

	// accumulator control for all lanes
	typedef struct packed {
		logic clear;
		logic accum;
	} lane_cmd_t;

	// stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic wr_off;
	} pipe_en_t;

endpackage

// ===== rtl/accel_offset_calibrator.sv =====
// ----------------------------------------------------------------------------
// accel_offset_calibrator: accelerometer offset calibration by averaging
// Sequencer, three axis lanes and the merge into the result word.
// ----------------------------------------------------------------------------
// One word is taken per clock while the stages have room, and its result
// passes stage 1 and stage 2 into the output register, which lets the input
// run on while a result waits. After the word that completes a calibration
// the input is held while that word is in stage 1 or stage 2, until the
// lanes' two-stage reciprocal multiply has produced the new offsets that the
// following y and z samples are corrected with. The fail limit register takes
// a write in any cycle; write it only while no word is in flight.
// ----------------------------------------------------------------------------
module accel_offset_calibrator #(
	parameter int unsigned TRIALS = aoc_pkg::TRIALS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  aoc_pkg::in_item_t            item,
	output logic                         result_valid,
	input  logic                         result_stall,
	output aoc_pkg::out_item_t           result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [aoc_pkg::LIMIT_W-1:0]  cfg_data
);

	logic                 accept;
	logic                 v_s1;
	logic                 v_s2;
	logic                 result_valid_q;
	aoc_pkg::stage_info_t info;
	aoc_pkg::stage_info_t info_s1;
	aoc_pkg::stage_info_t info_s2;
	aoc_pkg::lane_cmd_t   cmd;
	aoc_pkg::pipe_en_t    en;
	aoc_pkg::out_item_t   result_q;
	aoc_pkg::out_item_t   merged;
	logic                 out_free;
	logic                 s2_free;
	logic                 s1_free;
	logic                 hold;

	aoc_pkg::sample_t raw   [3];
	aoc_pkg::sample_t corr  [3];
	aoc_pkg::sample_t quot  [3];
	aoc_pkg::sample_t offset[3];
	aoc_pkg::sample_t in_sample[3];

	// advance each stage when the one after it has room
	assign out_free = !result_valid_q || !result_stall;
	assign s2_free  = !v_s2 || out_free;
	assign s1_free  = !v_s1 || s2_free;
	assign hold     = (v_s1 && info_s1.done) || (v_s2 && info_s2.done);

	assign item_stall = !s1_free || hold;
	assign accept     = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	assign en.s1     = accept;
	assign en.s2     = v_s1 && s2_free;
	assign en.wr_off = v_s2 && out_free && info_s2.done;

	aoc_ctrl #(
		.TRIALS(TRIALS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (item),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.cmd     (cmd),
		.info    (info)
	);

	assign in_sample[0] = item.acc_x;
	assign in_sample[1] = item.acc_y;
	assign in_sample[2] = item.acc_z;

	for (genvar g = 0; g < 3; g++) begin : g_lane
		aoc_lane #(
			.TRIALS(TRIALS)
		) u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.cmd   (cmd),
			.en    (en),
			.sample(in_sample[g]),
			.raw   (raw[g]),
			.corr  (corr[g]),
			.quot  (quot[g]),
			.offset(offset[g])
		);
	end

	// advance the per-word flags with the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s1_free) begin
				v_s1 <= accept;
			end
			if (s2_free) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			info_s1 <= info;
		end
		if (en.s2) begin
			info_s2 <= info_s1;
		end
	end

	// merge the lanes into the result word
	always_comb begin
		merged              = '0;
		merged.laser_cmd    = info_s2.laser_cmd;
		merged.calib_done   = info_s2.done;
		merged.calib_retry  = info_s2.retry;
		merged.sample_valid = info_s2.valid;
		if (info_s2.valid) begin
			merged.out_x = raw[0];
			merged.out_y = corr[1];
			merged.out_z = corr[2];
		end
		merged.offset_x = info_s2.done ? quot[0] : offset[0];
		merged.offset_y = info_s2.done ? quot[1] : offset[1];
		merged.offset_z = info_s2.done ? quot[2] : offset[2];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s2) begin
			result_q <= merged;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== rtl/aoc_ctrl.sv =====
// ----------------------------------------------------------------------------
// aoc_ctrl: calibration sequencer
// Keeps calibration, laser, sample count and failure state and decides, for
// each accepted word, the lane commands and the result flags.
// ----------------------------------------------------------------------------
module aoc_ctrl #(
	parameter int unsigned TRIALS = aoc_pkg::TRIALS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  aoc_pkg::in_item_t                 item,
	input  logic                              cfg_we,
	input  logic [aoc_pkg::LIMIT_W-1:0]       cfg_data,
	output aoc_pkg::lane_cmd_t                cmd,
	output aoc_pkg::stage_info_t              info
);

	localparam int unsigned CNT_W = $clog2(TRIALS + 1);

	logic                        cal_q;
	logic                        flash_q;
	logic [CNT_W-1:0]            count_q;
	logic [aoc_pkg::LIMIT_W-1:0] fail_q;
	logic [aoc_pkg::LIMIT_W-1:0] limit_q;

	logic                        cal_n;
	logic                        flash_n;
	logic [CNT_W-1:0]            count_n;
	logic [aoc_pkg::LIMIT_W-1:0] fail_n;
	logic [aoc_pkg::LIMIT_W-1:0] fail_inc;

	// decide the next state and the flags of this word
	always_comb begin
		cal_n    = cal_q;
		flash_n  = flash_q;
		count_n  = count_q;
		fail_n   = fail_q;
		fail_inc = '0;
		cmd      = '0;
		info     = '0;
		info.laser_cmd = aoc_pkg::LCMD_NONE;
		if (accept) begin
			if (item.op == aoc_pkg::OP_REQ) begin
				cal_n     = 1'b1;
				count_n   = '0;
				cmd.clear = 1'b1;
			end else if (cal_q) begin
				if (!flash_q) begin
					info.laser_cmd = aoc_pkg::LCMD_ON;
					if (item.laser_granted) begin
						flash_n = 1'b1;
						fail_n  = '0;
					end
				end else if (count_q == '0) begin
					fail_n = '0;
				end
				if (item.read_ok) begin
					fail_n    = '0;
					cmd.accum = 1'b1;
					count_n   = count_q + CNT_W'(1);
					if (count_n >= CNT_W'(TRIALS)) begin
						cal_n          = 1'b0;
						flash_n        = 1'b0;
						info.laser_cmd = aoc_pkg::LCMD_OFF;
						info.done      = 1'b1;
					end
				end else begin
					fail_inc = fail_n + aoc_pkg::LIMIT_W'(1);
					if (fail_inc >= limit_q) begin
						fail_n     = '0;
						count_n    = '0;
						cmd.clear  = 1'b1;
						info.retry = 1'b1;
					end else begin
						fail_n = fail_inc;
					end
				end
			end else if (item.read_ok) begin
				info.valid = 1'b1;
			end
		end
	end

	// hold sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q   <= 1'b0;
			flash_q <= 1'b0;
			count_q <= '0;
			fail_q  <= '0;
			limit_q <= aoc_pkg::FAIL_LIMIT_RESET;
		end else begin
			cal_q   <= cal_n;
			flash_q <= flash_n;
			count_q <= count_n;
			fail_q  <= fail_n;
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
		end
	end

endmodule

// ===== rtl/aoc_lane.sv =====
// ----------------------------------------------------------------------------
// aoc_lane: one axis lane
// Accumulates the axis sum, divides it by the trial count through a
// reciprocal multiply over two stages, holds the axis offset and removes it
// from the sample.
// ----------------------------------------------------------------------------
module aoc_lane #(
	parameter int unsigned TRIALS = aoc_pkg::TRIALS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  aoc_pkg::lane_cmd_t cmd,
	input  aoc_pkg::pipe_en_t  en,
	input  aoc_pkg::sample_t   sample,
	output aoc_pkg::sample_t   raw,
	output aoc_pkg::sample_t   corr,
	output aoc_pkg::sample_t   quot,
	output aoc_pkg::sample_t   offset
);

	// floor(n / TRIALS) == (n * RECIP) >> SHIFT for every n below 2**MAG_W
	localparam int unsigned L_W     = $clog2(TRIALS);
	localparam int unsigned SHIFT   = aoc_pkg::MAG_W + L_W;
	localparam int unsigned RECIP_W = aoc_pkg::MAG_W + 1;
	localparam int unsigned PROD_W  = aoc_pkg::MAG_W + RECIP_W;
	localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) + 64'(TRIALS) - 64'd1)
		/ 64'(TRIALS);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

	logic signed [aoc_pkg::SUM_W-1:0] sum_q;
	logic signed [aoc_pkg::SUM_W-1:0] sum_new;
	logic signed [aoc_pkg::SUM_W-1:0] sum_s1;
	aoc_pkg::sample_t                 raw_s1;
	logic [aoc_pkg::MAG_W-1:0]        mag;
	logic [PROD_W-1:0]                prod;
	logic [PROD_W-1:0]                prod_s2;
	logic [PROD_W-1:0]                shifted;
	logic                             neg_s2;
	aoc_pkg::sample_t                 raw_s2;
	aoc_pkg::sample_t                 offset_q;

	assign sum_new = sum_q + aoc_pkg::SUM_W'(sample);

	// clear or advance the axis sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.clear) begin
			sum_q <= '0;
		end else if (cmd.accum) begin
			sum_q <= sum_new;
		end
	end

	// stage 1: hold the updated sum and the raw sample
	always_ff @(posedge clk) begin
		if (en.s1) begin
			sum_s1 <= sum_new;
			raw_s1 <= sample;
		end
	end

	assign mag  = sum_s1[aoc_pkg::SUM_W-1] ? aoc_pkg::MAG_W'(-sum_s1)
		: aoc_pkg::MAG_W'(sum_s1);
	assign prod = PROD_W'(mag) * PROD_W'(RECIP);

	// stage 2: hold the reciprocal product
	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_s2 <= prod;
			neg_s2  <= sum_s1[aoc_pkg::SUM_W-1];
			raw_s2  <= raw_s1;
		end
	end

	// truncate toward zero: divide the magnitude, then restore the sign
	assign shifted = prod_s2 >> SHIFT;
	assign quot    = neg_s2 ? -aoc_pkg::sample_t'(shifted[aoc_pkg::SAMPLE_W-1:0])
		: aoc_pkg::sample_t'(shifted[aoc_pkg::SAMPLE_W-1:0]);

	// hold the offset of this axis
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (en.wr_off) begin
			offset_q <= quot;
		end
	end

	assign raw    = raw_s2;
	assign corr   = raw_s2 - offset_q;
	assign offset = offset_q;

endmodule

// ===== verif/accel_offset_calibrator_chk.sv =====
// ----------------------------------------------------------------------------
// accel_offset_calibrator_chk: result checker for the offset calibrator
// Watches the item, result and fail limit channels, works out the result
// of every accepted item and compares it field by field with the block's.
// ----------------------------------------------------------------------------
module accel_offset_calibrator_chk #(
	parameter int unsigned TRIALS = aoc_pkg::TRIALS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	input  logic                         item_stall,
	input  aoc_pkg::in_item_t            item,
	input  logic                         result_valid,
	input  logic                         result_stall,
	input  aoc_pkg::out_item_t           result,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [aoc_pkg::LIMIT_W-1:0]  cfg_data,
	output int                           mismatches,
	output int                           words_due
);

	// calibration state, kept in step with the block
	logic                              in_cal;
	logic                              lasers_on;
	logic signed [aoc_pkg::SUM_W-1:0]  sums [3];
	logic [10:0]                       n_good;
	logic [aoc_pkg::LIMIT_W-1:0]       n_fail;
	aoc_pkg::sample_t                  offs [3];
	logic [aoc_pkg::LIMIT_W-1:0]       fail_lim;

	aoc_pkg::out_item_t                outputs_due [$];
	aoc_pkg::out_item_t                want;
	int                                n_bad;

	function automatic void clear_sums();
		for (int k = 0; k < 3; k++)
			sums[k] = '0;
		n_good = '0;
	endfunction

	// advance the calibration by one word and return the result it causes
	function automatic aoc_pkg::out_item_t calibrator_step(input aoc_pkg::in_item_t w);
		aoc_pkg::out_item_t r;
		r = '0;
		r.laser_cmd = aoc_pkg::LCMD_NONE;
		if (w.op == aoc_pkg::OP_REQ) begin
			in_cal = 1'b1;
			clear_sums();
		end else if (in_cal) begin
			// keep asking for lasers until granted
			if (!lasers_on) begin
				r.laser_cmd = aoc_pkg::LCMD_ON;
				if (w.laser_granted) begin
					lasers_on = 1'b1;
					n_fail = '0;
				end
			end else if (n_good == 11'd0) begin
				n_fail = '0;
			end
			if (w.read_ok) begin
				n_fail = '0;
				sums[0] = sums[0] + aoc_pkg::SUM_W'(w.acc_x);
				sums[1] = sums[1] + aoc_pkg::SUM_W'(w.acc_y);
				sums[2] = sums[2] + aoc_pkg::SUM_W'(w.acc_z);
				n_good = n_good + 11'd1;
				if (n_good >= 11'(TRIALS)) begin
					in_cal = 1'b0;
					lasers_on = 1'b0;
					r.laser_cmd = aoc_pkg::LCMD_OFF;
					for (int k = 0; k < 3; k++)
						offs[k] = aoc_pkg::sample_t'(int'(sums[k]) / int'(TRIALS));
					r.calib_done = 1'b1;
				end
			end else begin
				// restart once the run of failed reads reaches the limit
				n_fail = n_fail + aoc_pkg::LIMIT_W'(1);
				if (n_fail >= fail_lim) begin
					n_fail = '0;
					clear_sums();
					r.calib_retry = 1'b1;
				end
			end
		end else if (w.read_ok) begin
			r.sample_valid = 1'b1;
			r.out_x = w.acc_x;
			r.out_y = w.acc_y - offs[1];
			r.out_z = w.acc_z - offs[2];
		end
		r.offset_x = offs[0];
		r.offset_y = offs[1];
		r.offset_z = offs[2];
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] got_v);
		if (exp_v !== got_v) begin
			if (n_bad < 10)
				$display("%0t: %s expected %h got %h", $time, name, exp_v, got_v);
			n_bad++;
		end
	endfunction

	// follow the channels, predict on input, compare on output
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cal = 1'b0;
			lasers_on = 1'b0;
			clear_sums();
			n_fail = '0;
			for (int k = 0; k < 3; k++)
				offs[k] = '0;
			fail_lim = aoc_pkg::FAIL_LIMIT_RESET;
			outputs_due.delete();
			n_bad = 0;
			mismatches <= 0;
			words_due <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				fail_lim = cfg_data;
			if (item_valid && !item_stall)
				outputs_due.push_back(calibrator_step(item));
			if (result_valid && !result_stall) begin
				if (outputs_due.size() == 0) begin
					if (n_bad < 10)
						$display("%0t: result word with none outstanding", $time);
					n_bad++;
				end else begin
					want = outputs_due.pop_front();
					check_field("laser_cmd", 16'(want.laser_cmd), 16'(result.laser_cmd));
					check_field("calib_done", 16'(want.calib_done), 16'(result.calib_done));
					check_field("calib_retry", 16'(want.calib_retry),
						16'(result.calib_retry));
					check_field("sample_valid", 16'(want.sample_valid),
						16'(result.sample_valid));
					check_field("out_x", want.out_x, result.out_x);
					check_field("out_y", want.out_y, result.out_y);
					check_field("out_z", want.out_z, result.out_z);
					check_field("offset_x", want.offset_x, result.offset_x);
					check_field("offset_y", want.offset_y, result.offset_y);
					check_field("offset_z", want.offset_z, result.offset_z);
				end
			end
			words_due <= outputs_due.size();
			mismatches <= n_bad;
		end
	end

endmodule

// ===== verif/accel_offset_calibrator_tb.sv =====
// ----------------------------------------------------------------------------
// accel_offset_calibrator_tb: stimulus and verdict for the offset calibrator
// Runs a directed opening, then phases of calibration runs with random
// samples, read failures and grants under several fail limits and idling
// patterns; the checker beside the block judges every result word.
// ----------------------------------------------------------------------------
module accel_offset_calibrator_tb;

	localparam int unsigned TRIALS = aoc_pkg::TRIALS_DEF;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         item_valid = 1'b0;
	logic                         item_stall;
	aoc_pkg::in_item_t            item = '0;
	logic                         result_valid;
	logic                         result_stall = 1'b0;
	aoc_pkg::out_item_t           result;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [aoc_pkg::LIMIT_W-1:0]  cfg_data = '0;

	int                           mismatches;
	int                           words_due;

	int                           snd_pct = 0;
	int                           rcv_pct = 0;
	int                           n_sent = 0;
	int                           cur_limit = int'(aoc_pkg::FAIL_LIMIT_RESET);
	int                           hold_reqs = 0;
	int                           hold_done = 0;
	int                           hold_left = 0;

	accel_offset_calibrator #(.TRIALS(TRIALS)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	accel_offset_calibrator_chk #(.TRIALS(TRIALS)) chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.words_due    (words_due)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// result side: long hold-offs on request, random stalls otherwise
	always @(posedge clk) begin
		if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_reqs != hold_done) begin
			result_stall <= 1'b1;
			hold_left <= 80;
			hold_done <= hold_done + 1;
		end else begin
			result_stall <= (rcv_pct != 0) && ($urandom_range(0, 99) < rcv_pct);
		end
	end

	function automatic logic rnd_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic aoc_pkg::sample_t rnd_sample();
		case ($urandom_range(0, 9))
			0: return aoc_pkg::sample_t'(16'h7fff);
			1: return aoc_pkg::sample_t'(16'h8000);
			2: return '0;
			default: return aoc_pkg::sample_t'($urandom());
		endcase
	endfunction

	function automatic aoc_pkg::in_item_t mk_word(input logic op, input logic ok,
			input logic grant);
		aoc_pkg::in_item_t w;
		w.op = op;
		w.read_ok = ok;
		w.acc_x = rnd_sample();
		w.acc_y = rnd_sample();
		w.acc_z = rnd_sample();
		w.laser_granted = grant;
		return w;
	endfunction

	function automatic aoc_pkg::in_item_t mk_fixed(input logic ok, input logic grant,
			input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
		aoc_pkg::in_item_t w;
		w = mk_word(aoc_pkg::OP_TICK, ok, grant);
		w.acc_x = x;
		w.acc_y = y;
		w.acc_z = z;
		return w;
	endfunction

	// offer one word, idling first at random, and hold it until taken
	task automatic send_word(input aoc_pkg::in_item_t w);
		while (snd_pct != 0 && $urandom_range(0, 99) < snd_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		n_sent++;
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_limit(input logic [aoc_pkg::LIMIT_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cur_limit = int'(v);
	endtask

	// one calibration run: request, grant hunt, good reads with failure bursts
	task automatic calib_session();
		int   good;
		int   burst;
		int   cap;
		logic granted;
		logic g;
		send_word(mk_word(aoc_pkg::OP_REQ, rnd_bit(), rnd_bit()));
		granted = 1'b0;
		good = 0;
		cap = (cur_limit <= 20) ? cur_limit + 1 : 12;
		while (good < TRIALS) begin
			if ($urandom_range(0, 3) == 0) begin
				if ($urandom_range(0, 29) == 0)
					burst = cur_limit + $urandom_range(0, 1);
				else
					burst = $urandom_range(1, cap);
				repeat (burst) begin
					g = granted ? rnd_bit() : ($urandom_range(0, 2) == 0);
					granted |= g;
					send_word(mk_word(aoc_pkg::OP_TICK, 1'b0, g));
				end
			end
			// abandon or restart now and then
			if ($urandom_range(0, 59) == 0)
				break;
			if ($urandom_range(0, 49) == 0) begin
				send_word(mk_word(aoc_pkg::OP_REQ, rnd_bit(), rnd_bit()));
				good = 0;
			end
			g = granted ? rnd_bit() : ($urandom_range(0, 2) == 0);
			granted |= g;
			send_word(mk_word(aoc_pkg::OP_TICK, 1'b1, g));
			good++;
		end
		// corrected samples afterwards
		repeat ($urandom_range(0, 8))
			send_word(mk_word(aoc_pkg::OP_TICK, $urandom_range(0, 3) != 0, rnd_bit()));
	endtask

	initial begin
		int phase_end;
		logic paused;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening at the reset fail limit
		send_word(mk_fixed(1'b0, 1'b1, 16'h7fff, 16'h8000, 16'h7fff));
		send_word(mk_fixed(1'b1, 1'b0, 16'h8000, 16'h7fff, 16'h8000));
		send_word(mk_fixed(1'b1, 1'b1, 16'h7fff, 16'h8000, 16'hffff));
		send_word(mk_word(aoc_pkg::OP_REQ, 1'b1, 1'b1));
		send_word(mk_fixed(1'b1, 1'b0, 16'h1234, 16'h8001, 16'h0001));
		// restart while calibrating, then fill without any grant
		send_word(mk_word(aoc_pkg::OP_REQ, 1'b0, 1'b0));
		repeat (TRIALS)
			send_word(mk_fixed(1'b1, 1'b0, 16'h7fff, 16'h8000, 16'h8000));
		send_word(mk_fixed(1'b1, 1'b1, 16'h8000, 16'h7fff, 16'h0000));
		send_word(mk_fixed(1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000));
		send_word(mk_word(aoc_pkg::OP_REQ, 1'b0, 1'b0));
		send_word(mk_fixed(1'b0, 1'b1, 16'hffff, 16'hffff, 16'hffff));
		drain();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: write_limit(8'd1);
				1: write_limit(8'd255);
				2: write_limit(8'd0);
				3: write_limit(aoc_pkg::LIMIT_W'($urandom_range(2, 12)));
				4: write_limit(aoc_pkg::FAIL_LIMIT_RESET);
				default: write_limit(aoc_pkg::LIMIT_W'($urandom_range(1, 255)));
			endcase
			if (p < 2) begin
				snd_pct = 22;
				rcv_pct <= 87;
			end else if (p < 4) begin
				snd_pct = 87;
				rcv_pct <= 22;
			end else begin
				snd_pct = 0;
				rcv_pct <= 0;
			end
			// hold the result side off while words keep coming
			if (p == 1 || p == 4)
				hold_reqs <= hold_reqs + 1;
			phase_end = n_sent + 190;
			paused = 1'b0;
			while (n_sent < phase_end) begin
				if ($urandom_range(0, 5) == 0) begin
					repeat ($urandom_range(1, 5))
						send_word(mk_word(rnd_bit(), rnd_bit(), rnd_bit()));
				end else begin
					calib_session();
				end
				if ((p == 2 || p == 5) && !paused && n_sent > phase_end - 100) begin
					drain();
					paused = 1'b1;
				end
			end
			drain();
		end

		if (mismatches == 0 && words_due == 0)
			$display("accel_offset_calibrator: match");
		else
			$display("accel_offset_calibrator: mismatch");
		$finish;
	end

	// give up on a hung run
	initial begin
		#4000000;
		$display("accel_offset_calibrator: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/aoc_pkg.sv
rtl/aoc_ctrl.sv
rtl/aoc_lane.sv
rtl/accel_offset_calibrator.sv
verif/accel_offset_calibrator_chk.sv
verif/accel_offset_calibrator_tb.sv
